// File: sv/ctrl_frame_receiver_crc16_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the control-frame receiver
// Clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef CTRL_FRAME_RECEIVER_CRC16_CORE_MACROS_SVH
`define CTRL_FRAME_RECEIVER_CRC16_CORE_MACROS_SVH

// same-cycle implication
`define CFRC16_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CFRC16_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/cfrc16_pkg.sv
// ----------------------------------------------------------------------------
// cfrc16_pkg
// Shared types, codes and the CRC-16 byte update for the frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfrc16_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_START_ONE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_TWO  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_VERSION    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAP_TMO    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_HUNT_TMO   = 3'd4;

  localparam logic [15:0] GAP_TMO_RESET  = 16'd20;
  localparam logic [15:0] HUNT_TMO_RESET = 16'd500;

  // event codes
  localparam logic [2:0] EV_PAYLOAD  = 3'd0;
  localparam logic [2:0] EV_GOOD     = 3'd1;
  localparam logic [2:0] EV_CRC_BAD  = 3'd2;
  localparam logic [2:0] EV_GAP_TMO  = 3'd3;
  localparam logic [2:0] EV_TOO_LONG = 3'd4;
  localparam logic [2:0] EV_HUNT_TMO = 3'd5;

  localparam logic       KIND_BYTE = 1'b0;
  localparam logic       KIND_TICK = 1'b1;

  localparam logic [15:0] MAX_PAYLOAD = 16'd256;
  localparam logic [15:0] CRC_POLY    = 16'h1021;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  data;
    logic [7:0]  message_type;
    logic [7:0]  sequence_res;
    logic [15:0] length;
  } result_t;

  typedef struct packed {
    logic [7:0]  start_byte_one;
    logic [7:0]  start_byte_two;
    logic [7:0]  protocol_version;
    logic [15:0] inter_byte_timeout;
    logic [15:0] hunt_timeout;
  } cfg_t;

  // CRC-16, MSB first, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: sv/cfrc16_cfg_regs.sv
// ----------------------------------------------------------------------------
// cfrc16_cfg_regs
// Configuration register bank, write only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfrc16_cfg_regs
  import cfrc16_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte_one     <= 8'd0;
      cfg.start_byte_two     <= 8'd0;
      cfg.protocol_version   <= 8'd0;
      cfg.inter_byte_timeout <= GAP_TMO_RESET;
      cfg.hunt_timeout       <= HUNT_TMO_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_ONE: cfg.start_byte_one     <= cfg_data[7:0];
        CFG_START_TWO: cfg.start_byte_two     <= cfg_data[7:0];
        CFG_VERSION:   cfg.protocol_version   <= cfg_data[7:0];
        CFG_GAP_TMO:   cfg.inter_byte_timeout <= cfg_data;
        CFG_HUNT_TMO:  cfg.hunt_timeout       <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: sv/cfrc16_engine.sv
// ----------------------------------------------------------------------------
// cfrc16_engine
// Input register, frame parser state and per-beat result decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ctrl_frame_receiver_crc16_core_macros.svh"

module cfrc16_engine
  import cfrc16_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item_beat,
  input  logic    queue_full,
  output logic    res_push,
  output result_t res_beat
);

  typedef enum logic [2:0] {
    PH_HUNT1   = 3'd0,
    PH_HUNT2   = 3'd1,
    PH_HEADER  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC_LO  = 3'd4,
    PH_CRC_HI  = 3'd5,
    PH_DROP    = 3'd6
  } phase_t;

  logic   s1_valid;
  item_t  s1_beat;
  logic   s1_go;

  phase_t      phase, phase_next;
  logic [2:0]  header_index, header_index_next;
  logic [7:0]  type_reg, type_reg_next;
  logic [7:0]  seq_reg, seq_reg_next;
  logic [15:0] length_reg, length_reg_next;
  logic [15:0] byte_count, byte_count_next;
  logic [15:0] crc_accum, crc_accum_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;
  logic [15:0] gap_ticks, gap_ticks_next;
  logic [15:0] hunt_ticks, hunt_ticks_next;

  logic [16:0] hunt_inc, gap_inc;
  logic [7:0]  b;
  logic [15:0] crc_upd;

  // held item only blocks a new one when the queue cannot take its result
  assign item_stall = s1_valid && queue_full;
  assign s1_go      = s1_valid && !queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
    if (item_valid && !item_stall) begin
      s1_beat <= item_beat;
    end
  end

  assign b        = s1_beat.data_byte;
  assign hunt_inc = {1'b0, hunt_ticks} + 17'd1;
  assign gap_inc  = {1'b0, gap_ticks} + 17'd1;
  assign crc_upd  = crc_byte(crc_accum, b);

  always_comb begin
    phase_next        = phase;
    header_index_next = header_index;
    type_reg_next     = type_reg;
    seq_reg_next      = seq_reg;
    length_reg_next   = length_reg;
    byte_count_next   = byte_count;
    crc_accum_next    = crc_accum;
    crc_low_byte_next = crc_low_byte;
    gap_ticks_next    = gap_ticks;
    hunt_ticks_next   = hunt_ticks;
    res_push          = 1'b0;
    res_beat          = '0;

    if (s1_go) begin
      if (s1_beat.kind == KIND_TICK) begin
        if (phase == PH_HUNT1) begin
          if (hunt_inc >= {1'b0, cfg.hunt_timeout}) begin
            hunt_ticks_next    = 16'd0;
            res_push           = 1'b1;
            res_beat.event_res = EV_HUNT_TMO;
          end else begin
            hunt_ticks_next = hunt_inc[15:0];
          end
        end else begin
          if (gap_inc >= {1'b0, cfg.inter_byte_timeout}) begin
            phase_next         = PH_HUNT1;
            gap_ticks_next     = 16'd0;
            hunt_ticks_next    = 16'd0;
            res_push           = 1'b1;
            res_beat.event_res = EV_GAP_TMO;
          end else begin
            gap_ticks_next = gap_inc[15:0];
          end
        end
      end else begin
        gap_ticks_next = 16'd0;
        case (phase)
          PH_HUNT2: begin
            if (b == cfg.start_byte_two) begin
              phase_next        = PH_HEADER;
              header_index_next = 3'd0;
              crc_accum_next    = 16'd0;
            end else begin
              phase_next = PH_HUNT1;
            end
          end
          PH_HEADER, PH_DROP: begin
            crc_accum_next = crc_upd;
            case (header_index)
              3'd0: if (b != cfg.protocol_version) phase_next = PH_DROP;
              3'd1: type_reg_next = b;
              3'd2: seq_reg_next = b;
              3'd3: length_reg_next = {8'd0, b};
              default: length_reg_next = {b, length_reg[7:0]};
            endcase
            if (header_index < 3'd4) begin
              header_index_next = header_index + 3'd1;
            end else begin
              header_index_next = 3'd0;
              if (phase == PH_DROP) begin
                phase_next = PH_HUNT1;
              end else if (length_reg_next > MAX_PAYLOAD) begin
                phase_next            = PH_HUNT1;
                hunt_ticks_next       = 16'd0;
                res_push              = 1'b1;
                res_beat.event_res    = EV_TOO_LONG;
                res_beat.message_type = type_reg;
                res_beat.sequence_res = seq_reg;
                res_beat.length       = length_reg_next;
              end else begin
                byte_count_next = 16'd0;
                phase_next = (length_reg_next == 16'd0) ? PH_CRC_LO : PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            crc_accum_next  = crc_upd;
            byte_count_next = byte_count + 16'd1;
            if (byte_count_next >= length_reg) phase_next = PH_CRC_LO;
            res_push              = 1'b1;
            res_beat.event_res    = EV_PAYLOAD;
            res_beat.data         = b;
            res_beat.message_type = type_reg;
            res_beat.sequence_res = seq_reg;
            res_beat.length       = length_reg;
          end
          PH_CRC_LO: begin
            crc_low_byte_next = b;
            phase_next        = PH_CRC_HI;
          end
          PH_CRC_HI: begin
            phase_next            = PH_HUNT1;
            hunt_ticks_next       = 16'd0;
            res_push              = 1'b1;
            res_beat.event_res    = ({b, crc_low_byte} == crc_accum) ? EV_GOOD : EV_CRC_BAD;
            res_beat.message_type = type_reg;
            res_beat.sequence_res = seq_reg;
            res_beat.length       = length_reg;
          end
          default: begin
            // hunting the first start byte
            phase_next = (b == cfg.start_byte_one) ? PH_HUNT2 : PH_HUNT1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT1;
      header_index <= 3'd0;
      type_reg     <= 8'd0;
      seq_reg      <= 8'd0;
      length_reg   <= 16'd0;
      byte_count   <= 16'd0;
      crc_accum    <= 16'd0;
      crc_low_byte <= 8'd0;
      gap_ticks    <= 16'd0;
      hunt_ticks   <= 16'd0;
    end else begin
      phase        <= phase_next;
      header_index <= header_index_next;
      type_reg     <= type_reg_next;
      seq_reg      <= seq_reg_next;
      length_reg   <= length_reg_next;
      byte_count   <= byte_count_next;
      crc_accum    <= crc_accum_next;
      crc_low_byte <= crc_low_byte_next;
      gap_ticks    <= gap_ticks_next;
      hunt_ticks   <= hunt_ticks_next;
    end
  end

  `CFRC16_ASSERT_IMP(a_push_room, res_push, s1_valid && !queue_full, "result pushed into full queue")
  `CFRC16_ASSERT_IMP(a_payload_len, phase == PH_PAYLOAD, (length_reg != 16'd0) && (length_reg <= MAX_PAYLOAD), "payload phase with bad length")
  `CFRC16_ASSERT_IMP(a_data_zero, res_push && (res_beat.event_res != EV_PAYLOAD), res_beat.data == 8'd0, "data set on non-payload event")
  `CFRC16_ASSERT_IMP(a_hdr_index, (phase == PH_HEADER) || (phase == PH_DROP), header_index <= 3'd4, "header index out of range")

endmodule

// File: sv/cfrc16_res_queue.sv
// ----------------------------------------------------------------------------
// cfrc16_res_queue
// Two-deep result queue: output register plus skid register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ctrl_frame_receiver_crc16_core_macros.svh"

module cfrc16_res_queue
  import cfrc16_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_beat,
  output logic    full,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result_beat
);

  logic    head_valid;
  logic    spare_valid;
  result_t spare_beat;
  logic    pop;

  assign pop          = head_valid && !result_stall;
  assign full         = spare_valid;
  assign result_valid = head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid  <= 1'b0;
      spare_valid <= 1'b0;
    end else begin
      if (pop || !head_valid) begin
        if (spare_valid) begin
          head_valid  <= 1'b1;
          result_beat <= spare_beat;
          spare_valid <= push;
          if (push) spare_beat <= push_beat;
        end else begin
          head_valid <= push;
          if (push) result_beat <= push_beat;
        end
      end else if (push) begin
        spare_valid <= 1'b1;
        spare_beat  <= push_beat;
      end
    end
  end

  `CFRC16_ASSERT_IMP(a_no_overflow, push, !spare_valid, "push while queue full")
  `CFRC16_ASSERT_IMP(a_order, spare_valid, head_valid, "skid holds a beat with empty head")
  `CFRC16_ASSERT_NXT(a_hold, head_valid && result_stall, head_valid && $stable(result_beat), "stalled result lost")

endmodule

// File: sv/ctrl_frame_receiver_crc16_core.sv
// ----------------------------------------------------------------------------
// ctrl_frame_receiver_crc16_core
// Control-frame receiver: start-byte hunt, header parse, CRC-16 verdict.
// ----------------------------------------------------------------------------
// Input channel (item_*): one beat is a received byte (kind 0) or a one
// millisecond tick (kind 1). A beat is taken on a clock edge with item_valid
// high and item_stall low.
// Output channel (result_*): zero or one event beat per input beat - payload
// byte, frame good, CRC mismatch, byte gap timeout, length too long or hunt
// timeout - taken on an edge with result_valid high and result_stall low.
// Config port: cfg_we writes cfg_data into register cfg_index, no read-back;
// write only while no beat is in flight.
// A taken beat waits in the input register; its event is decoded from there
// and pushed into the result queue, which offers it from its output register.
// Throughput: one beat per cycle while item_stall is low; the CRC byte update,
// the parser step and the timeout compares are all combinational between the
// input register and the result queue.
// Stall: the two-deep result queue absorbs a stalled receiver; item_stall
// rises only once the queue is full and a beat waits in the input register.
// Reset (rst, synchronous): parser back to hunting, counters and CRC clear,
// timeouts reload 20 and 500 ticks, start bytes and version clear to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctrl_frame_receiver_crc16_core
  import cfrc16_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // received bytes and ticks
  input  logic                   item_valid,
  output logic                   item_stall,
  input  item_t                  item_beat,
  // events
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result_beat,
  // configuration writes
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t    cfg;
  logic    queue_full;
  logic    res_push;
  result_t res_beat;

  // register bank
  cfrc16_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register and parser; one result decode per beat
  cfrc16_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item_beat  (item_beat),
    .queue_full (queue_full),
    .res_push   (res_push),
    .res_beat   (res_beat)
  );

  // output register with skid stage, decouples result_stall from item_stall
  cfrc16_res_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (res_push),
    .push_beat    (res_beat),
    .full         (queue_full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_beat  (result_beat)
  );

endmodule

// File: tb/sv/ctrl_frame_receiver_crc16_core_test.sv
// ----------------------------------------------------------------------------
// ctrl_frame_receiver_crc16_core_test
// Self-checking bench for the control-frame receiver. Byte and tick beats go
// in on a valid/stall channel. A cycle-free model of the parser predicts
// each event beat, and a monitor compares every accepted event field by
// field against the oldest prediction. Directed frames cover reset values
// and each special case. Random traffic then runs under several register
// settings, the extremes among them, mostly with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctrl_frame_receiver_crc16_core_test;
  import cfrc16_pkg::*;

  localparam int QUIET_LIMIT   = 1000;    // cycles with no beat on either side
  localparam int SETTLE_CYCLES = 8;       // parser latency plus margin
  localparam int ALL_BYTES     = 1 << 30;

  typedef enum logic [2:0] {
    P_HUNT_ONE, P_HUNT_TWO, P_HEADER, P_PAYLOAD, P_CRC_LO, P_CRC_HI, P_DROP
  } parse_phase_t;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   item_valid   = 1'b0;
  logic                   item_stall;
  item_t                  item_beat    = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  result_t                result_beat;
  logic                   cfg_we       = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;

  ctrl_frame_receiver_crc16_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item_beat    (item_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_beat  (result_beat),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // shadow registers and parser state of the model
  cfg_t         regs = '{8'h00, 8'h00, 8'h00, GAP_TMO_RESET, HUNT_TMO_RESET};
  parse_phase_t ph = P_HUNT_ONE;
  logic [2:0]   hdr_idx = '0;
  logic [7:0]   typ_q = '0, seq_q = '0, crc_lo_q = '0;
  logic [15:0]  len_q = '0, cnt_q = '0, crc_q = '0, gap_q = '0, hunt_q = '0;

  result_t expected_events[$];
  bit      calm = 1'b0;           // no idling on either side
  int      failures = 0;
  int      beats_sent = 0;
  int      events_seen = 0;
  int      settings_used = 0;
  int      ev_tally[6];

  // CRC-16/XMODEM, one bit at a time, MSB first
  function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc;
    for (int k = 7; k >= 0; k--) begin
      if (c[15] ^ b[k]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic void end_of_frame();
    ph     = P_HUNT_ONE;
    gap_q  = '0;
    hunt_q = '0;
  endfunction

  // one beat through the parser; returns 1 when it yields an event
  function automatic bit parse_step(input item_t it, output result_t ev);
    logic [16:0] nxt;
    logic [7:0]  b;
    bit          fire, hdr;
    b = it.data_byte;
    fire = 1'b0;
    hdr = 1'b0;
    ev = '0;
    if (it.kind == KIND_TICK) begin
      if (ph == P_HUNT_ONE) begin
        nxt = {1'b0, hunt_q} + 17'd1;
        if (nxt >= {1'b0, regs.hunt_timeout}) begin
          hunt_q = '0;
          fire = 1'b1;
          ev.event_res = EV_HUNT_TMO;
        end else begin
          hunt_q = nxt[15:0];
        end
      end else begin
        nxt = {1'b0, gap_q} + 17'd1;
        if (nxt >= {1'b0, regs.inter_byte_timeout}) begin
          end_of_frame();
          fire = 1'b1;
          ev.event_res = EV_GAP_TMO;
        end else begin
          gap_q = nxt[15:0];
        end
      end
    end else begin
      gap_q = '0;
      case (ph)
        P_HUNT_ONE: begin
          if (b == regs.start_byte_one) ph = P_HUNT_TWO;
        end
        P_HUNT_TWO: begin
          // a wrong second byte is dropped, not retried as a first one
          if (b == regs.start_byte_two) begin
            ph = P_HEADER;
            hdr_idx = '0;
            crc_q = '0;
          end else begin
            ph = P_HUNT_ONE;
          end
        end
        P_HEADER, P_DROP: begin
          crc_q = crc16_update(crc_q, b);
          case (hdr_idx)
            3'd0: if (b != regs.protocol_version) ph = P_DROP;
            3'd1: typ_q = b;
            3'd2: seq_q = b;
            3'd3: len_q = {8'h00, b};
            default: len_q = {b, len_q[7:0]};
          endcase
          if (hdr_idx < 3'd4) begin
            hdr_idx = hdr_idx + 3'd1;
          end else begin
            hdr_idx = '0;
            if (ph == P_DROP) begin
              ph = P_HUNT_ONE;
            end else if (len_q > MAX_PAYLOAD) begin
              end_of_frame();
              fire = 1'b1;
              hdr = 1'b1;
              ev.event_res = EV_TOO_LONG;
            end else begin
              cnt_q = '0;
              ph = (len_q == 16'd0) ? P_CRC_LO : P_PAYLOAD;
            end
          end
        end
        P_PAYLOAD: begin
          crc_q = crc16_update(crc_q, b);
          cnt_q = cnt_q + 16'd1;
          if (cnt_q >= len_q) ph = P_CRC_LO;
          fire = 1'b1;
          hdr = 1'b1;
          ev.event_res = EV_PAYLOAD;
          ev.data = b;
        end
        P_CRC_LO: begin
          crc_lo_q = b;
          ph = P_CRC_HI;
        end
        default: begin
          end_of_frame();
          fire = 1'b1;
          hdr = 1'b1;
          ev.event_res = ({b, crc_lo_q} == crc_q) ? EV_GOOD : EV_CRC_BAD;
        end
      endcase
    end
    if (hdr) begin
      ev.message_type = typ_q;
      ev.sequence_res = seq_q;
      ev.length = len_q;
    end
    return fire;
  endfunction

  // sender: optional idle burst, then hold the beat until taken
  task automatic send_beat(input logic kind, input logic [7:0] b);
    item_t   it;
    result_t ev;
    it.kind = kind;
    it.data_byte = b;
    if (!calm && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item_beat  <= it;
    do @(posedge clk); while (item_stall);
    beats_sent++;
    if (parse_step(it, ev)) expected_events.push_back(ev);
  endtask

  task automatic send_tick();
    send_beat(KIND_TICK, 8'($urandom_range(0, 255)));
  endtask

  // hold the sender off until every predicted event has been taken
  task automatic drain_events();
    item_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // all five registers, back to back, while the parser is idle
  task automatic apply_settings(input cfg_t s);
    drain_events();
    cfg_we <= 1'b1;
    cfg_index <= CFG_START_ONE;
    cfg_data  <= {8'h00, s.start_byte_one};
    @(posedge clk);
    cfg_index <= CFG_START_TWO;
    cfg_data  <= {8'h00, s.start_byte_two};
    @(posedge clk);
    cfg_index <= CFG_VERSION;
    cfg_data  <= {8'h00, s.protocol_version};
    @(posedge clk);
    cfg_index <= CFG_GAP_TMO;
    cfg_data  <= s.inter_byte_timeout;
    @(posedge clk);
    cfg_index <= CFG_HUNT_TMO;
    cfg_data  <= s.hunt_timeout;
    @(posedge clk);
    cfg_we <= 1'b0;
    regs = s;
    settings_used++;
  endtask

  // start bytes, header, then payload and CRC when version and length are valid;
  // only the first keep bytes go out. Ticks short of the gap limit are sprinkled between bytes.
  task automatic send_frame(input logic [7:0] ver, input logic [15:0] len, input bit crc_ok,
                            input int keep);
    logic [7:0]  fb[$];
    logic [7:0]  typ, seq;
    logic [15:0] crc;
    int          spare;
    typ = 8'($urandom_range(0, 255));
    seq = 8'($urandom_range(0, 255));
    fb = '{regs.start_byte_one, regs.start_byte_two, ver, typ, seq, len[7:0], len[15:8]};
    if (ver == regs.protocol_version && len <= MAX_PAYLOAD) begin
      repeat (len) fb.push_back(8'($urandom_range(0, 255)));
      crc = '0;
      for (int i = 2; i < fb.size(); i++) crc = crc16_update(crc, fb[i]);
      if (!crc_ok) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      fb.push_back(crc[7:0]);
      fb.push_back(crc[15:8]);
    end
    spare = (regs.inter_byte_timeout > 16'd4) ? 3 : int'(regs.inter_byte_timeout) - 1;
    for (int i = 0; i < fb.size() && i < keep; i++) begin
      if (i > 0 && spare > 0 && $urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, spare)) send_tick();
      send_beat(KIND_BYTE, fb[i]);
    end
  endtask

  task automatic send_random_frame(input bit broken);
    int          r;
    logic [15:0] len;
    logic [7:0]  ver;
    r = $urandom_range(0, 99);
    if (r < 65) len = 16'($urandom_range(0, 6));
    else if (r < 85) len = 16'($urandom_range(7, 40));
    else if (r < 87) len = 16'($urandom_range(250, 256));
    else if (r < 90) len = ($urandom_range(0, 1) != 0) ? 16'd257 : 16'hFFFF;
    else len = 16'($urandom_range(257, 65535));
    ver = regs.protocol_version;
    if ($urandom_range(0, 9) == 0) ver = ver ^ 8'($urandom_range(1, 255));
    send_frame(ver, len, $urandom_range(0, 3) != 0,
               broken ? int'($urandom_range(1, 9)) : ALL_BYTES);
    // abandoned frame: let the gap timer expire where that is cheap
    if (broken && regs.inter_byte_timeout <= 16'd64)
      repeat (regs.inter_byte_timeout) send_tick();
  endtask

  task automatic send_noise();
    int r;
    repeat ($urandom_range(1, 6)) begin
      r = $urandom_range(0, 9);
      if (r < 4) send_tick();
      else if (r == 4) send_beat(KIND_BYTE, regs.start_byte_one);
      else if (r == 5) send_beat(KIND_BYTE, regs.start_byte_two);
      else send_beat(KIND_BYTE, 8'($urandom_range(0, 255)));
    end
  endtask

  // mostly well-formed frames, some cut short, some noise; one mid-run
  // hold-off until the result side has caught up
  task automatic run_traffic(input int n_beats);
    int first, pick;
    bit paused;
    first = beats_sent;
    paused = 1'b0;
    while (beats_sent - first < n_beats) begin
      if (!paused && beats_sent - first > n_beats / 2) begin
        paused = 1'b1;
        drain_events();
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) send_random_frame(1'b0);
      else if (pick < 72) send_random_frame(1'b1);
      else send_noise();
    end
  endtask

  function automatic cfg_t random_settings(input int gap_hi, input int hunt_hi);
    cfg_t s;
    s.start_byte_one     = 8'($urandom_range(0, 255));
    s.start_byte_two     = 8'($urandom_range(0, 255));
    s.protocol_version   = 8'($urandom_range(0, 255));
    s.inter_byte_timeout = 16'($urandom_range(2, gap_hi));
    s.hunt_timeout       = 16'($urandom_range(2, hunt_hi));
    return s;
  endfunction

  // ---- tests ----

  // reset values: zero start bytes and version, zero-length frame
  task automatic test_reset_values();
    send_frame(8'h00, 16'd0, 1'b1, ALL_BYTES);
  endtask

  task automatic test_special_cases();
    apply_settings('{8'hAA, 8'h55, 8'h01, 16'd3, 16'd4});
    // largest length, flagged as too long
    send_frame(8'h01, 16'hFFFF, 1'b1, ALL_BYTES);
    // wrong second start byte that equals the first: must not restart
    send_beat(KIND_BYTE, 8'hAA);
    send_beat(KIND_BYTE, 8'hAA);
    send_beat(KIND_BYTE, 8'h55);
    // wrong version: header eaten, no event
    send_frame(8'h02, 16'd1, 1'b1, ALL_BYTES);
    // gap timeout straight after the first start byte
    send_beat(KIND_BYTE, 8'hAA);
    repeat (3) send_tick();
    // hunt window runs out
    repeat (4) send_tick();
  endtask

  task automatic test_random_frames();
    apply_settings(random_settings(8, 40));
    send_frame(regs.protocol_version, MAX_PAYLOAD, 1'b1, ALL_BYTES);
    run_traffic(120);
    apply_settings(random_settings(30, 300));
    run_traffic(120);
  endtask

  task automatic test_extreme_settings();
    // every tick inside a frame or while hunting reports
    apply_settings('{8'h00, 8'hFF, 8'hFF, 16'd1, 16'd1});
    run_traffic(100);
    apply_settings('{8'hFF, 8'h00, 8'h00, 16'hFFFF, 16'hFFFF});
    run_traffic(100);
  endtask

  // identical start bytes, no idling anywhere
  task automatic test_unpaused_stream();
    cfg_t s;
    s = random_settings(6, 12);
    s.start_byte_two = s.start_byte_one;
    apply_settings(s);
    calm = 1'b1;
    run_traffic(90);
  endtask

  // ---- receiver backpressure: stall bursts and free-running stretches ----
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        result_stall <= 1'b0;
      end else if ($urandom_range(0, 15) == 0) begin
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end
    end
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endfunction

  // ---- event monitor ----
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      events_seen++;
      if (expected_events.size() == 0) begin
        $error("event beat with nothing expected: event_res 0x%0h", result_beat.event_res);
        failures++;
      end else begin
        want = expected_events.pop_front();
        check_field("event_res", 16'(want.event_res), 16'(result_beat.event_res));
        check_field("data", 16'(want.data), 16'(result_beat.data));
        check_field("message_type", 16'(want.message_type), 16'(result_beat.message_type));
        check_field("sequence_res", 16'(want.sequence_res), 16'(result_beat.sequence_res));
        check_field("length", want.length, result_beat.length);
        if (want.event_res <= EV_HUNT_TMO) ev_tally[want.event_res]++;
      end
    end
  end

  // ---- watchdog: no beat on either side for too long ----
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("watchdog: no beat for %0d cycles, %0d events outstanding",
             QUIET_LIMIT, expected_events.size());
    $display("** ctrl_frame_receiver_crc16_core: FAILED **");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_special_cases();
    test_random_frames();
    test_extreme_settings();
    test_unpaused_stream();
    drain_events();
    if (expected_events.size() != 0) begin
      $error("%0d expected events never arrived", expected_events.size());
      failures++;
    end
    $display("Ran %0d beats in, %0d events out, over %0d register settings.",
             beats_sent, events_seen, settings_used + 1);
    $display("Events: payload %0d, good %0d, crc bad %0d, gap %0d, too long %0d, hunt %0d.",
             ev_tally[0], ev_tally[1], ev_tally[2], ev_tally[3], ev_tally[4], ev_tally[5]);
    if (failures == 0)
      $display("** ctrl_frame_receiver_crc16_core: PASSED **");
    else
      $display("** ctrl_frame_receiver_crc16_core: FAILED **");
    $finish;
  end

endmodule
